// File: rtl/core/spq_pkg.sv
// spq_pkg: types and constants shared by the sorted priority queue
// no dependencies

package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_WIDTH   = 32;
   localparam int COUNT_WIDTH   = 5;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      func_type                       func;
      logic signed [VALUE_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  head_value;
      logic                           is_empty;
      logic [COUNT_WIDTH-1:0]         entry_count;
      status_type                     status;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                           insert;
      logic                           remove;
      logic signed [VALUE_WIDTH-1:0]  value;
   } cell_ctl_type;

endpackage

// File: rtl/core/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue kept sorted in a chain of cells
// depends on spq_pkg and spq_cell
//
//   channel   ports                      direction   handshake
//   request   start, busy, req_item      in          start && !busy
//   response  rsp_strobe, rsp_item       out         rsp_strobe, one cycle
//
// every cell compares the new value in parallel and shifts by one place,
// so the next item may follow at once
// the response appears in the cycle after the item is taken
// busy stays low: the chain never stalls and the receiver cannot stall
// synchronous reset empties the queue; stored values keep stale data

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                   accept;
   logic                   full;
   logic                   empty;
   cell_ctl_type           ctl;

   logic [CW-1:0]          count_ff, count_in;
   logic                   strobe_ff;
   status_type             status_ff, status_in;
   logic [CW+COUNT_WIDTH-1:0] count_ext;

   logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic                          cell_valid [DEPTH];
   logic                          cell_gt    [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   // decode the operation into a chain-wide command
   always_comb begin
      ctl.insert = 1'b0;
      ctl.remove = 1'b0;
      ctl.value  = req_item.value;
      count_in   = count_ff;
      status_in  = status_ff;
      if (accept) begin
         status_in = STATUS_OK;
         case (req_item.func)
            FUNC_INSERT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            FUNC_REMOVE: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  ctl.remove = 1'b1;
                  count_in   = count_ff - 1'b1;
               end
            end
            default: status_in = STATUS_OK;
         endcase
      end
   end

   // the chain, head at cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] prev_value, next_value;
      logic                          prev_valid, prev_gt, next_valid;

      if (i == 0) begin : g_head
         assign prev_value = '0;
         assign prev_valid = 1'b0;
         assign prev_gt    = 1'b1;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_gt    = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = '0;
         assign next_valid = 1'b0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_gt    (prev_gt),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .gt         (cell_gt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
         status_ff <= status_in;
      end
   end

   // response is read straight from the updated chain head and counter
   assign count_ext = {{COUNT_WIDTH{1'b0}}, count_ff};

   assign rsp_strobe           = strobe_ff;
   assign rsp_item.head_value  = cell_valid[0] ? cell_value[0] : '0;
   assign rsp_item.is_empty    = empty;
   assign rsp_item.entry_count = count_ext[COUNT_WIDTH-1:0];
   assign rsp_item.status      = status_ff;

endmodule

// File: rtl/core/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds a value and a valid bit
// depends on spq_pkg

module spq_cell
   import spq_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cell_ctl_type                   ctl,
   input  logic signed [VALUE_WIDTH-1:0]  prev_value,
   input  logic                           prev_valid,
   input  logic                           prev_gt,
   input  logic signed [VALUE_WIDTH-1:0]  next_value,
   input  logic                           next_valid,
   output logic signed [VALUE_WIDTH-1:0]  value,
   output logic                           valid,
   output logic                           gt
);

   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          valid_ff, valid_in;

   // stored entry outranks the new value
   assign gt = valid_ff && (value_ff > ctl.value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.insert) begin
         if (!gt) begin
            if (prev_gt) begin
               value_in = ctl.value;
               valid_in = 1'b1;
            end else begin
               value_in = prev_value;
               valid_in = prev_valid;
            end
         end
      end else if (ctl.remove) begin
         value_in = next_value;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// File: rtl/core/spq_checker.sv
// spq_checker: port-level assertions for the sorted priority queue
// depends on spq_pkg; bound to sorted_priority_queue

module spq_checker
   import spq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // one response for each item, in the cycle after it is taken
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_strobe == $past(start && !busy)))
      else $error("response strobe does not follow accepted item");

   // empty queue reports zero head
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.is_empty) |-> (rsp_item.head_value == '0))
      else $error("empty queue shows nonzero head");

   // empty queue reports zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.is_empty) |-> (rsp_item.entry_count == '0))
      else $error("empty queue shows nonzero count");

   // full status only after an insert, empty status only after a remove
   a_status_func: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != STATUS_OK) |->
         ((rsp_item.status == STATUS_FULL && $past(req_item.func) == FUNC_INSERT) ||
          (rsp_item.status == STATUS_EMPTY && $past(req_item.func) == FUNC_REMOVE &&
           rsp_item.is_empty)))
      else $error("status does not match operation");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
